>>> hdl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// Lamp column centroid package
// Shared constants, register indexes and types for the centroid block.
// ----------------------------------------------------------------------------
package lcc_pkg;

	// Frame geometry.
	localparam int IMG_WIDTH     = 80;
	localparam int MAX_ROWS      = 64;
	localparam int BYTES_PER_ROW = (IMG_WIDTH + 7) / 8;
	localparam int LANES         = 8;
	localparam int BYTE_W        = $clog2(BYTES_PER_ROW);

	// Field widths.
	localparam int ROW_W   = 6;
	localparam int WCOL_W  = 7;
	localparam int COL_W   = WCOL_W + 1;
	localparam int TOT_W   = 13;
	localparam int CNT_W   = 7;
	localparam int IDX_W   = 3;
	localparam int DSTEP_W = $clog2(TOT_W);

	localparam logic [TOT_W-1:0] TOTAL_MAX = '1;
	localparam logic [CNT_W-1:0] ROWS_MAX  = '1;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_FIRST_ROW   = 3'd0;
	localparam logic [IDX_W-1:0] REG_LAST_ROW    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SPLIT_ROW   = 3'd2;
	localparam logic [IDX_W-1:0] REG_UPPER_LEFT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_UPPER_RIGHT = 3'd4;
	localparam logic [IDX_W-1:0] REG_LOWER_LEFT  = 3'd5;
	localparam logic [IDX_W-1:0] REG_LOWER_RIGHT = 3'd6;

	// Reset values of the registers.
	localparam logic [ROW_W-1:0]  RST_FIRST_ROW   = 6'd3;
	localparam logic [ROW_W-1:0]  RST_LAST_ROW    = 6'd40;
	localparam logic [ROW_W-1:0]  RST_SPLIT_ROW   = 6'd15;
	localparam logic [WCOL_W-1:0] RST_UPPER_LEFT  = 7'd20;
	localparam logic [WCOL_W-1:0] RST_UPPER_RIGHT = 7'd60;
	localparam logic [WCOL_W-1:0] RST_LOWER_LEFT  = 7'd10;
	localparam logic [WCOL_W-1:0] RST_LOWER_RIGHT = 7'd70;

	// What one lane found in its pixel.
	typedef struct packed {
		logic first_hit;
		logic last_hit;
	} lane_hit_t;

	// Summary of a closed row, handed to the accumulator.
	typedef struct packed {
		logic              examined;
		logic              first_seen;
		logic              last_seen;
		logic [WCOL_W-1:0] first_col;
		logic [WCOL_W-1:0] last_col;
		logic [WCOL_W-1:0] win_start;
		logic [WCOL_W-1:0] win_end;
	} row_sum_t;

	// Request from the accumulator to the divider.
	typedef struct packed {
		logic             start;
		logic [TOT_W-1:0] total;
		logic [CNT_W-1:0] rows;
	} div_req_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

endpackage

>>> hdl/lcc_lane.sv
// ----------------------------------------------------------------------------
// Lamp column centroid pixel lane
// Tests one pixel of a beat against the left and right search ranges.
// ----------------------------------------------------------------------------
module lcc_lane (
	input  logic [lcc_pkg::COL_W-1:0]  col,
	input  logic                       pixel,
	input  logic [lcc_pkg::WCOL_W-1:0] win_start,
	input  logic [lcc_pkg::WCOL_W-1:0] win_end,
	output lcc_pkg::lane_hit_t         hit
);
	import lcc_pkg::*;

	logic [COL_W-1:0] s_ext;
	logic [COL_W-1:0] e_ext;
	logic             lit;

	// A pixel only counts inside the row and when it is set.
	assign s_ext = {1'b0, win_start};
	assign e_ext = {1'b0, win_end};
	assign lit   = pixel && (32'(col) < IMG_WIDTH);

	// Left search covers start..end+1, right search covers start-1..end.
	assign hit.first_hit = lit && (col >= s_ext) && ({1'b0, col} <= {1'b0, e_ext} + 9'd1);
	assign hit.last_hit  = lit && ({1'b0, col} + 9'd1 >= {1'b0, s_ext}) && (col <= e_ext);

endmodule

>>> hdl/lcc_row_acc.sv
// ----------------------------------------------------------------------------
// Lamp column centroid row accumulator
// Turns a closed row into its midpoint and keeps the saturating totals.
// ----------------------------------------------------------------------------
module lcc_row_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              row_vld,
	input  logic              frame_end,
	input  lcc_pkg::row_sum_t row_sum,
	output lcc_pkg::div_req_t div_req
);
	import lcc_pkg::*;

	logic [TOT_W-1:0] total_q;
	logic [CNT_W-1:0] rows_q;
	logic [COL_W-1:0] left_bnd;
	logic [COL_W-1:0] right_bnd;
	logic [COL_W:0]   bnd_sum;
	logic [COL_W-1:0] mid;
	logic [TOT_W:0]   tot_sum;
	logic             counts;
	logic [TOT_W-1:0] total_n;
	logic [CNT_W-1:0] rows_n;

	// Bounds of the row, with the left bound held at zero near the edge.
	always_comb begin
		if (row_sum.first_col == row_sum.win_start) begin
			left_bnd = {1'b0, row_sum.win_start};
		end else if (row_sum.first_col >= 7'd2) begin
			left_bnd = {1'b0, row_sum.first_col - 7'd2};
		end else begin
			left_bnd = '0;
		end
		if (row_sum.last_col == row_sum.win_end) begin
			right_bnd = {1'b0, row_sum.win_end};
		end else begin
			right_bnd = {1'b0, row_sum.last_col} + 8'd2;
		end
		bnd_sum = {1'b0, left_bnd} + {1'b0, right_bnd};
		mid     = bnd_sum[COL_W:1];
	end

	// Saturating update of the totals for a row with both bounds.
	always_comb begin
		counts  = row_vld && row_sum.examined && row_sum.first_seen && row_sum.last_seen
			&& (row_sum.win_start <= row_sum.win_end);
		tot_sum = {1'b0, total_q} + {{(TOT_W+1-COL_W){1'b0}}, mid};
		total_n = total_q;
		rows_n  = rows_q;
		if (counts) begin
			total_n = (tot_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tot_sum[TOT_W-1:0];
			rows_n  = (rows_q == ROWS_MAX) ? rows_q : rows_q + 7'd1;
		end
	end

	// The frame end hands the final totals to the divider and clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			rows_q  <= '0;
		end else if (row_vld && frame_end) begin
			total_q <= '0;
			rows_q  <= '0;
		end else begin
			total_q <= total_n;
			rows_q  <= rows_n;
		end
	end

	assign div_req.start = row_vld && frame_end;
	assign div_req.total = total_n;
	assign div_req.rows  = rows_n;

endmodule

>>> hdl/lcc_divider.sv
// ----------------------------------------------------------------------------
// Lamp column centroid divider
// Restoring divider, one quotient bit per cycle, holds its result until taken.
// ----------------------------------------------------------------------------
module lcc_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lcc_pkg::div_req_t         div_req,
	input  logic                      res_ready,
	output logic                      res_valid,
	output logic [lcc_pkg::CNT_W-1:0] quotient,
	output logic [lcc_pkg::CNT_W-1:0] rows
);
	import lcc_pkg::*;

	div_state_t         state_q;
	div_state_t         state_n;
	logic [DSTEP_W-1:0] step_q;
	logic [TOT_W-1:0]   quo_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   dvs_q;
	logic [CNT_W:0]     trial;
	logic               fits;
	logic               last_step;

	// One trial subtraction per cycle.
	assign trial     = {rem_q, quo_q[TOT_W-1]};
	assign fits      = trial >= {1'b0, dvs_q};
	assign last_step = (32'(step_q) == TOT_W - 1);

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (div_req.start) state_n = DIV_RUN;
			end
			DIV_RUN: begin
				if (last_step) state_n = DIV_DONE;
			end
			DIV_DONE: begin
				if (res_ready) state_n = DIV_IDLE;
			end
			default: state_n = DIV_IDLE;
		endcase
	end

	// Outputs; a zero row count gives zero.
	always_comb begin
		res_valid = (state_q == DIV_DONE);
		quotient  = (dvs_q == '0) ? '0 : quo_q[CNT_W-1:0];
		rows      = dvs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == DIV_RUN) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// Dividend shifts out on top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && div_req.start) begin
			quo_q <= div_req.total;
			rem_q <= '0;
			dvs_q <= div_req.rows;
		end else if (state_q == DIV_RUN) begin
			quo_q <= {quo_q[TOT_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
		end
	end

endmodule

>>> hdl/lamp_column_centroid.sv
// ----------------------------------------------------------------------------
// Lamp column centroid
// Finds lamp bounds per row of a packed binary frame and averages midpoints.
// ----------------------------------------------------------------------------
// Pixel beats are taken one per clock during a frame: eight lanes test the
// eight pixels of a beat at once and a merge picks the leftmost and rightmost
// hits. After the beat that ends the frame, input is held off while the frame
// passes the row stage, the accumulator, the 13 steps of the bit-serial
// divider and the result handover, plus any time the result register still
// waits on the downstream side. Each frame yields one output beat with the
// centre column in bits 6:0 and the row count in 13:7.
module lamp_column_centroid (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration write port.
	input  logic                      wr_en,
	input  logic [lcc_pkg::IDX_W-1:0] wr_index,
	input  logic [lcc_pkg::WCOL_W-1:0] wr_data,
	// Pixel stream.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // pixel_byte [7:0]
	input  logic                      s_tlast,   // last_of_frame
	// Result stream.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [15:0]               m_tdata    // centre_column [6:0], rows_counted [13:7]
);
	import lcc_pkg::*;

	// Configuration registers.
	logic [ROW_W-1:0]  first_row_q;
	logic [ROW_W-1:0]  last_row_q;
	logic [ROW_W-1:0]  split_row_q;
	logic [WCOL_W-1:0] upper_left_q;
	logic [WCOL_W-1:0] upper_right_q;
	logic [WCOL_W-1:0] lower_left_q;
	logic [WCOL_W-1:0] lower_right_q;

	// Row tracking.
	logic [ROW_W-1:0]  row_idx_q;
	logic [BYTE_W-1:0] byte_idx_q;
	logic              first_seen_q;
	logic              last_seen_q;
	logic [WCOL_W-1:0] first_col_q;
	logic [WCOL_W-1:0] last_col_q;
	logic              busy_q;

	// Row stage.
	logic              row_vld_s1;
	logic              frame_end_s1;
	row_sum_t          row_s1;

	// Output register.
	logic              out_valid_q;
	logic [15:0]       out_data_q;

	logic              accept;
	logic              row_close;
	logic [WCOL_W-1:0] win_start;
	logic [WCOL_W-1:0] win_end;
	logic              examined;
	logic [COL_W-1:0]  lane_col [LANES];
	lane_hit_t         lane_hit [LANES];
	logic              first_seen_n;
	logic              last_seen_n;
	logic [WCOL_W-1:0] first_col_n;
	logic [WCOL_W-1:0] last_col_n;
	div_req_t          div_req;
	logic              res_ready;
	logic              res_valid;
	logic [CNT_W-1:0]  res_quo;
	logic [CNT_W-1:0]  res_rows;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !busy_q;
	assign row_close = (32'(byte_idx_q) == BYTES_PER_ROW - 1) || s_tlast;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_row_q   <= RST_FIRST_ROW;
			last_row_q    <= RST_LAST_ROW;
			split_row_q   <= RST_SPLIT_ROW;
			upper_left_q  <= RST_UPPER_LEFT;
			upper_right_q <= RST_UPPER_RIGHT;
			lower_left_q  <= RST_LOWER_LEFT;
			lower_right_q <= RST_LOWER_RIGHT;
		end else if (wr_en) begin
			case (wr_index)
				REG_FIRST_ROW:   first_row_q   <= wr_data[ROW_W-1:0];
				REG_LAST_ROW:    last_row_q    <= wr_data[ROW_W-1:0];
				REG_SPLIT_ROW:   split_row_q   <= wr_data[ROW_W-1:0];
				REG_UPPER_LEFT:  upper_left_q  <= wr_data;
				REG_UPPER_RIGHT: upper_right_q <= wr_data;
				REG_LOWER_LEFT:  lower_left_q  <= wr_data;
				REG_LOWER_RIGHT: lower_right_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Window and scan range of the current row.
	always_comb begin
		if (row_idx_q < split_row_q) begin
			win_start = upper_left_q;
			win_end   = upper_right_q;
		end else begin
			win_start = lower_left_q;
			win_end   = lower_right_q;
		end
		examined = (row_idx_q >= first_row_q) && (row_idx_q <= last_row_q)
			&& (32'(row_idx_q) < MAX_ROWS);
	end

	// One lane per pixel of the beat, most significant bit leftmost.
	for (genvar b = 0; b < LANES; b++) begin : g_lane
		assign lane_col[b] = COL_W'({byte_idx_q, 3'(b)});
		lcc_lane u_lane (
			.col       (lane_col[b]),
			.pixel     (s_tdata[LANES-1-b]),
			.win_start (win_start),
			.win_end   (win_end),
			.hit       (lane_hit[b])
		);
	end

	// Merge: the leftmost hit sets the first lamp once per row, the
	// rightmost hit always moves the last lamp.
	always_comb begin
		first_seen_n = first_seen_q;
		first_col_n  = first_col_q;
		last_seen_n  = last_seen_q;
		last_col_n   = last_col_q;
		for (int b = LANES - 1; b >= 0; b--) begin
			if (!first_seen_q && lane_hit[b].first_hit) begin
				first_seen_n = 1'b1;
				first_col_n  = lane_col[b][WCOL_W-1:0];
			end
		end
		for (int b = 0; b < LANES; b++) begin
			if (lane_hit[b].last_hit) begin
				last_seen_n = 1'b1;
				last_col_n  = lane_col[b][WCOL_W-1:0];
			end
		end
	end

	// Row position and candidates; a closed row restarts them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_idx_q    <= '0;
			byte_idx_q   <= '0;
			first_seen_q <= 1'b0;
			last_seen_q  <= 1'b0;
			first_col_q  <= '0;
			last_col_q   <= '0;
		end else if (accept) begin
			if (row_close) begin
				byte_idx_q   <= '0;
				row_idx_q    <= s_tlast ? '0 : row_idx_q + 1'b1;
				first_seen_q <= 1'b0;
				last_seen_q  <= 1'b0;
				first_col_q  <= '0;
				last_col_q   <= '0;
			end else begin
				byte_idx_q   <= byte_idx_q + 1'b1;
				first_seen_q <= first_seen_n;
				last_seen_q  <= last_seen_n;
				first_col_q  <= first_col_n;
				last_col_q   <= last_col_n;
			end
		end
	end

	// Row stage: the summary of a row as it closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_s1   <= 1'b0;
			frame_end_s1 <= 1'b0;
		end else begin
			row_vld_s1   <= accept && row_close;
			frame_end_s1 <= accept && s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && row_close) begin
			row_s1.examined   <= examined;
			row_s1.first_seen <= first_seen_n;
			row_s1.last_seen  <= last_seen_n;
			row_s1.first_col  <= first_col_n;
			row_s1.last_col   <= last_col_n;
			row_s1.win_start  <= win_start;
			row_s1.win_end    <= win_end;
		end
	end

	lcc_row_acc u_row_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_vld   (row_vld_s1),
		.frame_end (frame_end_s1),
		.row_sum   (row_s1),
		.div_req   (div_req)
	);

	assign res_ready = !out_valid_q || m_tready;

	lcc_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.div_req   (div_req),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.quotient  (res_quo),
		.rows      (res_rows)
	);

	// Input is held off from the frame end until its result is handed over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept && s_tlast) begin
			busy_q <= 1'b1;
		end else if (res_valid && res_ready) begin
			busy_q <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= {2'b00, res_rows, res_quo};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lamp column centroid testbench
// Streams packed binary frames into the centroid block under random flow
// control and checks each frame result against a cycle-free model of the
// row bound search and the midpoint averaging.
// ----------------------------------------------------------------------------
module tb;
	import lcc_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_BEATS  = 900;
	localparam int MIN_FRAMES    = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int TIMEOUT_NS    = 3_000_000;

	// One frame result, laid out as in the result beat.
	typedef struct packed {
		logic [CNT_W-1:0]  rows;
		logic [WCOL_W-1:0] centre;
	} centroid_t;

	typedef logic [0:IMG_WIDTH-1] line_t;

	// Directed steps: a pixel beat (data = pixel byte, aux = last of frame)
	// or a register write (data = register index, aux = value).
	typedef enum bit {STEP_BEAT, STEP_REG} step_kind_t;
	typedef struct packed {
		step_kind_t        kind;
		logic [7:0]        data;
		logic [WCOL_W-1:0] aux;
		logic              typed;
		centroid_t         want;
	} dir_step_t;

	localparam int DIR_LEN = 21;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [WCOL_W-1:0] wr_data;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;

	// Expected frame results, oldest first.
	centroid_t centroid_q[$];
	int err_cnt = 0;
	int beats_sent = 0;
	int frames_seen = 0;
	int hold_len = 0;
	bit src_burst = 1'b0;
	bit sink_burst = 1'b0;

	// Register copies.
	int r_first, r_last, r_split, r_ul, r_ur, r_ll, r_lr;

	// Row scan and frame accumulation state.
	int cur_row, byte_pos;
	int lead_col, trail_col;
	bit lead_seen, trail_seen;
	int mid_total, mid_rows;

	dir_step_t dir_tab [DIR_LEN] = '{
		// Rows before first_row are not examined at reset.
		'{STEP_BEAT, 8'hFF, 7'd1, 1'b1, '{7'd0, 7'd0}},
		'{STEP_BEAT, 8'h00, 7'd1, 1'b1, '{7'd0, 7'd0}},
		'{STEP_REG, 8'(REG_FIRST_ROW), 7'd0, 1'b0, '0},
		// A full row 0 in the upper window 20..60: a lamp just left of the
		// window, one inside, one just right of it, and pixels far outside.
		'{STEP_BEAT, 8'hFF, 7'd0, 1'b0, '0},
		'{STEP_BEAT, 8'h00, 7'd0, 1'b0, '0},
		'{STEP_BEAT, 8'h10, 7'd0, 1'b0, '0},
		'{STEP_BEAT, 8'h80, 7'd0, 1'b0, '0},
		'{STEP_BEAT, 8'h00, 7'd0, 1'b0, '0},
		'{STEP_BEAT, 8'h00, 7'd0, 1'b0, '0},
		'{STEP_BEAT, 8'h00, 7'd0, 1'b0, '0},
		'{STEP_BEAT, 8'h04, 7'd0, 1'b0, '0},
		'{STEP_BEAT, 8'h00, 7'd0, 1'b0, '0},
		'{STEP_BEAT, 8'h01, 7'd1, 1'b0, '0},
		// Empty window: start after end gives no bounds.
		'{STEP_REG, 8'(REG_UPPER_LEFT), 7'd78, 1'b0, '0},
		'{STEP_REG, 8'(REG_UPPER_RIGHT), 7'd1, 1'b0, '0},
		'{STEP_BEAT, 8'hFF, 7'd1, 1'b1, '{7'd0, 7'd0}},
		// Widest window, lamp run touching its start.
		'{STEP_REG, 8'(REG_UPPER_LEFT), 7'd1, 1'b0, '0},
		'{STEP_REG, 8'(REG_UPPER_RIGHT), 7'd78, 1'b0, '0},
		'{STEP_BEAT, 8'h7F, 7'd1, 1'b0, '0},
		// Short frame ending on the second byte of a row.
		'{STEP_BEAT, 8'h00, 7'd0, 1'b0, '0},
		'{STEP_BEAT, 8'h01, 7'd1, 1'b0, '0}
	};

	lamp_column_centroid DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // pixel_byte [7:0]
		.s_tlast  (s_tlast),   // last_of_frame
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // centre_column [6:0], rows_counted [13:7]
	);

	always #5 clk = ~clk;

	// Window of a row: upper rows lie below the split row.
	function automatic void window_of(input int row, output int s, output int e);
		if (row < r_split) begin
			s = r_ul;
			e = r_ur;
		end else begin
			s = r_ll;
			e = r_lr;
		end
	endfunction

	function automatic void clear_frame();
		cur_row = 0;
		byte_pos = 0;
		lead_col = 0;
		trail_col = 0;
		lead_seen = 1'b0;
		trail_seen = 1'b0;
		mid_total = 0;
		mid_rows = 0;
	endfunction

	// Close the current row: fold its midpoint into the frame totals.
	function automatic void close_row();
		int s, e, lb, rb;
		if (cur_row >= r_first && cur_row <= r_last && cur_row < MAX_ROWS) begin
			window_of(cur_row, s, e);
			if (s <= e && lead_seen && trail_seen) begin
				if (lead_col == s)
					lb = s;
				else
					lb = (lead_col >= 2) ? lead_col - 2 : 0;
				rb = (trail_col == e) ? e : trail_col + 2;
				mid_total += (lb + rb) >> 1;
				if (mid_total > int'(TOTAL_MAX))
					mid_total = int'(TOTAL_MAX);
				if (mid_rows < int'(ROWS_MAX))
					mid_rows++;
			end
		end
		lead_seen = 1'b0;
		trail_seen = 1'b0;
		lead_col = 0;
		trail_col = 0;
		byte_pos = 0;
		cur_row = (cur_row + 1) & 63;
	endfunction

	// Scan one pixel byte; on the last byte of a frame produce its result.
	function automatic void centroid_step(input logic [7:0] pix, input bit last,
			output bit emit, output centroid_t res);
		int s, e, c;
		if (byte_pos >= BYTES_PER_ROW)
			byte_pos = 0;
		window_of(cur_row, s, e);
		for (int b = 0; b < 8; b++) begin
			c = byte_pos * 8 + b;
			if (c < IMG_WIDTH && pix[7 - b]) begin
				if (!lead_seen && c >= s && c <= e + 1) begin
					lead_col = c;
					lead_seen = 1'b1;
				end
				if (c + 1 >= s && c <= e) begin
					trail_col = c;
					trail_seen = 1'b1;
				end
			end
		end
		byte_pos++;
		if (byte_pos >= BYTES_PER_ROW || last)
			close_row();
		emit = last;
		res = '0;
		if (last) begin
			res.centre = (mid_rows == 0) ? '0 : WCOL_W'((mid_total / mid_rows) & 127);
			res.rows = CNT_W'(mid_rows & 127);
			clear_frame();
		end
	endfunction

	task automatic note_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// Send one pixel beat after a random gap and record what it should yield.
	task automatic send_beat(input logic [7:0] pix, input bit last,
			input bit typed = 1'b0, input centroid_t typed_res = '0);
		int gap;
		bit emit;
		centroid_t res;
		gap = src_burst ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
		centroid_step(pix, last, emit, res);
		if (emit)
			centroid_q.push_back(typed ? typed_res : res);
	endtask

	// Stop sending and wait until every frame result is back and the block is idle.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (centroid_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input int val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= WCOL_W'(val);
		@(posedge clk);
		case (idx)
			REG_FIRST_ROW:   r_first = val & 63;
			REG_LAST_ROW:    r_last = val & 63;
			REG_SPLIT_ROW:   r_split = val & 63;
			REG_UPPER_LEFT:  r_ul = val & 127;
			REG_UPPER_RIGHT: r_ur = val & 127;
			REG_LOWER_LEFT:  r_ll = val & 127;
			REG_LOWER_RIGHT: r_lr = val & 127;
			default: ;
		endcase
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_regs(input int fr, input int lst, input int sp,
			input int ul, input int ur, input int ll, input int lr);
		settle();
		cfg_write(REG_FIRST_ROW, fr);
		cfg_write(REG_LAST_ROW, lst);
		cfg_write(REG_SPLIT_ROW, sp);
		cfg_write(REG_UPPER_LEFT, ul);
		cfg_write(REG_UPPER_RIGHT, ur);
		cfg_write(REG_LOWER_LEFT, ll);
		cfg_write(REG_LOWER_RIGHT, lr);
	endtask

	// A column that is often close to one of the window edges.
	function automatic int pick_col();
		int c;
		if ($urandom_range(0, 1))
			return $urandom_range(0, IMG_WIDTH - 1);
		case ($urandom_range(0, 3))
			0: c = r_ul;
			1: c = r_ur;
			2: c = r_ll;
			default: c = r_lr;
		endcase
		c = c + $urandom_range(0, 4) - 2;
		if (c < 0)
			c = 0;
		if (c > IMG_WIDTH - 1)
			c = IMG_WIDTH - 1;
		return c;
	endfunction

	// One image row: mostly a lamp run, sometimes empty or pure noise.
	function automatic line_t make_line();
		line_t line;
		int a, z, t, kind;
		line = '0;
		kind = $urandom_range(0, 9);
		if (kind == 1) begin
			for (int j = 0; j < BYTES_PER_ROW; j++)
				line[8*j +: 8] = 8'($urandom);
		end else if (kind != 0) begin
			a = pick_col();
			z = pick_col();
			if (a > z) begin
				t = a;
				a = z;
				z = t;
			end
			if (z - a > 12 && $urandom_range(0, 1))
				z = a + $urandom_range(0, 3);
			for (int c = a; c <= z; c++)
				line[c] = 1'b1;
			if (kind == 2)
				line[pick_col()] = 1'b1;
		end
		return line;
	endfunction

	// A frame of full rows followed by a final row of tail bytes.
	task automatic send_frame(input int full_rows, input int tail);
		line_t line;
		int n;
		for (int r = 0; r <= full_rows; r++) begin
			line = make_line();
			n = (r == full_rows) ? tail : BYTES_PER_ROW;
			for (int j = 0; j < n; j++)
				send_beat(line[8*j +: 8], r == full_rows && j == n - 1);
		end
	endtask

	// Result side: random back-pressure, with one long hold-off on request.
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			gap = sink_burst ? 0 : $urandom_range(0, 9);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Compare each result beat with the oldest expected frame result.
	always @(posedge clk) begin
		centroid_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[13:0];
			frames_seen++;
			if (centroid_q.size() == 0) begin
				note_error($sformatf("unexpected result centre %0d rows %0d",
					got.centre, got.rows));
			end else begin
				want = centroid_q.pop_front();
				if (got.centre !== want.centre)
					note_error($sformatf("centre_column expected %0d got %0d",
						want.centre, got.centre));
				if (got.rows !== want.rows)
					note_error($sformatf("rows_counted expected %0d got %0d",
						want.rows, got.rows));
			end
		end
	end

	// Stimulus.
	initial begin
		int phase, rnd_base, nrows, fr, ul, ur, ll, lr, t;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		r_first = RST_FIRST_ROW;
		r_last = RST_LAST_ROW;
		r_split = RST_SPLIT_ROW;
		r_ul = RST_UPPER_LEFT;
		r_ur = RST_UPPER_RIGHT;
		r_ll = RST_LOWER_LEFT;
		r_lr = RST_LOWER_RIGHT;
		clear_frame();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed steps.
		for (int i = 0; i < DIR_LEN; i++) begin
			if (dir_tab[i].kind == STEP_REG) begin
				settle();
				cfg_write(dir_tab[i].data[IDX_W-1:0], int'(dir_tab[i].aux));
			end else begin
				send_beat(dir_tab[i].data, dir_tab[i].aux[0], dir_tab[i].typed,
					dir_tab[i].want);
			end
		end

		// Random phases, each with its own register setting.
		rnd_base = beats_sent;
		phase = 0;
		while (beats_sent - rnd_base < RANDOM_BEATS || frames_seen < MIN_FRAMES) begin
			case (phase)
				0: load_regs(0, 62, 63, 1, 78, 1, 78);
				1: load_regs(63, 0, 0, 78, 1, 78, 1);
				2: load_regs(0, 62, 4, 1, 1, 78, 78);
				default: begin
					fr = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(0, 63);
					ul = $urandom_range(1, 78);
					ur = $urandom_range(1, 78);
					ll = $urandom_range(1, 78);
					lr = $urandom_range(1, 78);
					if (ul > ur && $urandom_range(0, 3) != 0) begin
						t = ul;
						ul = ur;
						ur = t;
					end
					if (ll > lr && $urandom_range(0, 3) != 0) begin
						t = ll;
						ll = lr;
						lr = t;
					end
					load_regs(fr, $urandom_range(0, 62), $urandom_range(0, 63), ul, ur, ll, lr);
				end
			endcase
			src_burst = (phase % 3 == 1);
			sink_burst = (phase % 4 == 3);

			// Hold the result side off while short frames keep arriving.
			if (phase == 2) begin
				hold_len = HOLD_CYCLES;
				repeat (8) send_frame(0, $urandom_range(1, BYTES_PER_ROW));
			end

			repeat (3) begin
				if ($urandom_range(0, 7) == 0)
					nrows = $urandom_range(7, 70);
				else
					nrows = $urandom_range(0, 6);
				send_frame(nrows, $urandom_range(1, BYTES_PER_ROW));
			end
			phase++;
		end

		settle();
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog.
	initial begin
		#(TIMEOUT_NS);
		$display("status: fail");
		$finish;
	end

endmodule
